// ===== hw/rtl/ncc_pkg.sv =====
// Shared types, constants and reset values for the nearest centroid confusion counter.
package ncc_pkg;

  localparam int NUM_CLASSES = 6;
  localparam int COUNT_BITS  = 16;
  localparam int SAMPLE_W    = 12;
  localparam int DIST_W      = SAMPLE_W + 2;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int MEM_DEPTH   = NUM_CLASSES * NUM_CLASSES;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int IDX_PORT_W  = 3;
  localparam int WIN_PORT_W  = 3;
  localparam int CNT_PORT_W  = 16;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_CLASSIFY = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_READ     = 2'd3
  } ncc_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_SEL,
    ST_READ,
    ST_COUNT
  } ncc_state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
  } ncc_point_t;

  typedef logic [DIST_W-1:0]     ncc_dist_t;
  typedef logic [COUNT_BITS-1:0] ncc_count_t;

  typedef struct packed {
    logic             en;
    logic [CLS_W-1:0] idx;
    ncc_point_t       point;
  } ncc_centre_wr_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    ncc_count_t        wr_data;
    logic              clear;
  } ncc_mem_req_t;

  function automatic ncc_point_t centre_reset(input int i);
    ncc_point_t p;
    case (i)
      0:       p = '{x: 12'd1533, y: 12'd1539, z: 12'd1235};
      1:       p = '{x: 12'd1835, y: 12'd1534, z: 12'd1536};
      2:       p = '{x: 12'd1535, y: 12'd1831, z: 12'd1536};
      3:       p = '{x: 12'd1540, y: 12'd1534, z: 12'd1834};
      4:       p = '{x: 12'd1230, y: 12'd1537, z: 12'd1535};
      5:       p = '{x: 12'd1534, y: 12'd1234, z: 12'd1535};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/ncc_centres.sv =====
// Centre point registers and registered Manhattan distances from the sample to each centre.
module ncc_centres (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ncc_pkg::ncc_centre_wr_t wr_i,
  input  ncc_pkg::ncc_point_t    sample_i,
  output ncc_pkg::ncc_dist_t     dist_o [ncc_pkg::NUM_CLASSES]
);

  ncc_pkg::ncc_point_t centres_q [ncc_pkg::NUM_CLASSES];
  ncc_pkg::ncc_dist_t  dist_d    [ncc_pkg::NUM_CLASSES];
  ncc_pkg::ncc_dist_t  dist_q    [ncc_pkg::NUM_CLASSES];

  function automatic logic [ncc_pkg::SAMPLE_W-1:0] abs_diff(
    input logic [ncc_pkg::SAMPLE_W-1:0] a,
    input logic [ncc_pkg::SAMPLE_W-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ncc_pkg::NUM_CLASSES; i++) begin
        centres_q[i] <= ncc_pkg::centre_reset(i);
      end
    end else if (wr_i.en) begin
      centres_q[wr_i.idx] <= wr_i.point;
    end
  end

  always_comb begin
    for (int i = 0; i < ncc_pkg::NUM_CLASSES; i++) begin
      dist_d[i] = ncc_pkg::DIST_W'(abs_diff(sample_i.x, centres_q[i].x))
                + ncc_pkg::DIST_W'(abs_diff(sample_i.y, centres_q[i].y))
                + ncc_pkg::DIST_W'(abs_diff(sample_i.z, centres_q[i].z));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ncc_pkg::NUM_CLASSES; i++) begin
      dist_q[i] <= dist_d[i];
    end
  end

  assign dist_o = dist_q;

endmodule

// ===== hw/rtl/ncc_count_mem.sv =====
// Confusion counter memory with registered read and per-entry valid bits for clearing.
module ncc_count_mem (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ncc_pkg::ncc_mem_req_t req_i,
  output ncc_pkg::ncc_count_t   rd_data_o
);

  ncc_pkg::ncc_count_t               mem [ncc_pkg::MEM_DEPTH];
  ncc_pkg::ncc_count_t               rd_data_q;
  logic [ncc_pkg::MEM_DEPTH-1:0]     vld_q;
  logic                              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/nearest_centroid_confusion_counter_top.sv =====
// Top level: request sequencer, nearest centre selection and confusion counter update.
//
//   Channel   Signals                                           Direction  Handshake
//   request   start_i, req_type_i, sample_*_i, true_class_i,    in         start_i & !busy_o
//             centre_index_i
//   result    done_o, winner_o, min_distance_o, count_value_o   out        done_o, one cycle
//
// From acceptance to the result strobe a request passes through distances, selection, counter
// memory read, and update with the output register. busy_o stays high from acceptance
// until the result word is registered, and a new word may be accepted in the cycle that shows
// the result. The result word then stays on the ports until the next request updates it.
// Reset restores the stored centre points and marks every counter as zero at once.
// done_o is high for one cycle only; the receiver cannot stall it.
module nearest_centroid_confusion_counter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] sample_x_i,
  input  logic [11:0] sample_y_i,
  input  logic [11:0] sample_z_i,
  input  logic [2:0]  true_class_i,
  input  logic [2:0]  centre_index_i,
  output logic        done_o,
  output logic [2:0]  winner_o,
  output logic [13:0] min_distance_o,
  output logic [15:0] count_value_o
);

  ncc_pkg::ncc_state_e   state_q, state_d;
  ncc_pkg::ncc_req_e     req_q;
  ncc_pkg::ncc_point_t   sample_q;
  logic [ncc_pkg::CLS_W-1:0]  row_q, col_q, win_q, win_d;
  logic                  row_ok_q, col_ok_q;
  ncc_pkg::ncc_dist_t    mind_q, mind_d;
  logic [ncc_pkg::ADDR_W-1:0] addr_q, addr_d;
  ncc_pkg::ncc_dist_t    centre_dist [ncc_pkg::NUM_CLASSES];
  ncc_pkg::ncc_centre_wr_t centre_wr;
  ncc_pkg::ncc_mem_req_t mem_req;
  ncc_pkg::ncc_count_t   rd_cnt, new_cnt;
  logic                  accept;
  logic                  done_q;
  logic [ncc_pkg::WIN_PORT_W-1:0] winner_q;
  ncc_pkg::ncc_dist_t    min_dist_q;
  logic [ncc_pkg::CNT_PORT_W-1:0] count_q;

  assign accept = start_i && (state_q == ncc_pkg::ST_IDLE);
  assign busy_o = (state_q != ncc_pkg::ST_IDLE);

  ncc_centres u_centres (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (centre_wr),
    .sample_i (sample_q),
    .dist_o   (centre_dist)
  );

  ncc_count_mem u_count_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_cnt)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ncc_pkg::ST_IDLE:  if (start_i) state_d = ncc_pkg::ST_DIST;
      ncc_pkg::ST_DIST:  state_d = ncc_pkg::ST_SEL;
      ncc_pkg::ST_SEL:   state_d = ncc_pkg::ST_READ;
      ncc_pkg::ST_READ:  state_d = ncc_pkg::ST_COUNT;
      ncc_pkg::ST_COUNT: state_d = ncc_pkg::ST_IDLE;
      default:           state_d = ncc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    win_d  = '0;
    mind_d = centre_dist[0];
    for (int i = 1; i < ncc_pkg::NUM_CLASSES; i++) begin
      if (centre_dist[i] < mind_d) begin
        mind_d = centre_dist[i];
        win_d  = ncc_pkg::CLS_W'(i);
      end
    end
  end

  always_comb begin
    if (req_q == ncc_pkg::REQ_CLASSIFY) begin
      addr_d = ncc_pkg::ADDR_W'(int'(win_q) * ncc_pkg::NUM_CLASSES + int'(col_q));
    end else begin
      addr_d = ncc_pkg::ADDR_W'(int'(row_q) * ncc_pkg::NUM_CLASSES + int'(col_q));
    end
    new_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
  end

  always_comb begin
    centre_wr       = '0;
    centre_wr.idx   = row_q;
    centre_wr.point = sample_q;
    mem_req         = '0;
    mem_req.rd_addr = addr_d;
    mem_req.wr_addr = addr_q;
    mem_req.wr_data = new_cnt;
    case (state_q)
      ncc_pkg::ST_DIST: begin
        centre_wr.en  = (req_q == ncc_pkg::REQ_LOAD) && row_ok_q;
        mem_req.clear = (req_q == ncc_pkg::REQ_CLEAR);
      end
      ncc_pkg::ST_READ: begin
        mem_req.rd_en = ((req_q == ncc_pkg::REQ_CLASSIFY) && col_ok_q)
                     || ((req_q == ncc_pkg::REQ_READ) && row_ok_q && col_ok_q);
      end
      ncc_pkg::ST_COUNT: begin
        mem_req.wr_en = (req_q == ncc_pkg::REQ_CLASSIFY) && col_ok_q;
      end
      default: begin
        mem_req.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ncc_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ncc_pkg::ST_COUNT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= ncc_pkg::ncc_req_e'(req_type_i);
      sample_q   <= '{x: sample_x_i, y: sample_y_i, z: sample_z_i};
      row_q      <= ncc_pkg::CLS_W'(centre_index_i);
      col_q      <= ncc_pkg::CLS_W'(true_class_i);
      row_ok_q   <= (32'(centre_index_i) < ncc_pkg::NUM_CLASSES);
      col_ok_q   <= (32'(true_class_i) < ncc_pkg::NUM_CLASSES);
    end
    if (state_q == ncc_pkg::ST_SEL) begin
      win_q  <= win_d;
      mind_q <= mind_d;
    end
    if (state_q == ncc_pkg::ST_READ) begin
      addr_q <= addr_d;
    end
    if (state_q == ncc_pkg::ST_COUNT) begin
      if (req_q == ncc_pkg::REQ_CLASSIFY) begin
        winner_q   <= ncc_pkg::WIN_PORT_W'(win_q);
        min_dist_q <= mind_q;
        count_q    <= col_ok_q ? ncc_pkg::CNT_PORT_W'(new_cnt) : '0;
      end else begin
        winner_q   <= '0;
        min_dist_q <= '0;
        count_q    <= ((req_q == ncc_pkg::REQ_READ) && row_ok_q && col_ok_q)
                    ? ncc_pkg::CNT_PORT_W'(rd_cnt) : '0;
      end
    end
  end

  assign done_o         = done_q;
  assign winner_o       = winner_q;
  assign min_distance_o = min_dist_q;
  assign count_value_o  = count_q;

endmodule
